// File: rtl/fpa_pkg.sv
// Package for the Q24.8 fixed-point ALU: operation codes, widths and defaults.
// Used by every module of the ALU; depends on nothing.
package fpa_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned OpWidth = 3;
  localparam int unsigned FracBitsDefault = 8;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4,
    OP_I2F = 3'd5,
    OP_F2I = 3'd6,
    OP_NOP = 3'd7
  } op_t;

endpackage

// File: rtl/fpa_div_pipe.sv
// Pipelined signed divider: quotient of a NumWidth-bit dividend (64 by default) by a 32-bit divisor,
// truncated toward zero, low 32 bits kept, one quotient bit per stage.
// Uses fpa_pkg for the data width.
module fpa_div_pipe #(
  parameter int unsigned NumWidth = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [NumWidth-1:0]             in_num_mag,
  input  logic [fpa_pkg::DataWidth-1:0]   in_den_mag,
  input  logic                            in_neg,
  output logic                            out_valid,
  output logic [fpa_pkg::DataWidth-1:0]   out_quot
);

  localparam int unsigned DW = fpa_pkg::DataWidth;
  localparam int unsigned RemWidth = DW + 1;

  logic                              vld_r [1:NumWidth];
  logic [NumWidth-1:0]               num_r [1:NumWidth];
  logic [RemWidth-1:0]               rem_r [1:NumWidth];
  logic [DW-1:0]                     den_r [1:NumWidth];
  logic                              neg_r [1:NumWidth];

  for (genvar s = 0; s < NumWidth; s++) begin : g_stage
    logic                vld_cur;
    logic [NumWidth-1:0] num_cur;
    logic [RemWidth-1:0] rem_cur;
    logic [DW-1:0]       den_cur;
    logic                neg_cur;
    logic [RemWidth-1:0] shifted;
    logic [RemWidth:0]   diff;
    logic [RemWidth-1:0] rem_nxt;
    logic [NumWidth-1:0] num_nxt;

    if (s == 0) begin : g_head
      assign vld_cur = in_valid;
      assign num_cur = in_num_mag;
      assign rem_cur = '0;
      assign den_cur = in_den_mag;
      assign neg_cur = in_neg;
    end else begin : g_body
      assign vld_cur = vld_r[s];
      assign num_cur = num_r[s];
      assign rem_cur = rem_r[s];
      assign den_cur = den_r[s];
      assign neg_cur = neg_r[s];
    end

    always_comb begin
      shifted = {rem_cur[RemWidth-2:0], num_cur[NumWidth-1]};
      diff = {1'b0, shifted} - {2'b00, den_cur};
      if (!diff[RemWidth]) begin
        rem_nxt = diff[RemWidth-1:0];
        num_nxt = {num_cur[NumWidth-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        num_nxt = {num_cur[NumWidth-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_cur;
      end
      num_r[s+1] <= num_nxt;
      rem_r[s+1] <= rem_nxt;
      den_r[s+1] <= den_cur;
      neg_r[s+1] <= neg_cur;
    end
  end

  assign out_valid = vld_r[NumWidth];
  assign out_quot = neg_r[NumWidth] ? (~num_r[NumWidth][DW-1:0] + DW'(1))
                                    : num_r[NumWidth][DW-1:0];

endmodule

// File: rtl/fixed_point_alu_q24_8.sv
// Q24.8 fixed-point ALU: add, subtract, multiply, divide, compare and conversions.
// Uses fpa_pkg and instantiates the pipelined divider fpa_div_pipe.
// A request is taken on every cycle (busy is always low) and its result appears
// with out_valid, whatever the operation. The divider resolves one quotient bit
// per stage over the 32 + FRAC_BITS bits of the shifted dividend.
// Every operation travels through the same delay line so results leave in order.
// The receiver cannot stall: each result is shown for one cycle only.
module fixed_point_alu_q24_8 #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [fpa_pkg::OpWidth-1:0]            in_req_type,
  input  logic signed [fpa_pkg::DataWidth-1:0]   in_operand_a,
  input  logic signed [fpa_pkg::DataWidth-1:0]   in_operand_b,
  output logic                                   out_valid,
  output logic signed [fpa_pkg::DataWidth-1:0]   out_result_value,
  output logic                                   out_is_less,
  output logic                                   out_is_equal,
  output logic                                   out_is_greater,
  output logic                                   out_divide_by_zero
);

  localparam int unsigned DW = fpa_pkg::DataWidth;
  localparam int unsigned NumWidth = DW + FRAC_BITS;
  localparam int unsigned DelayLen = NumWidth - 1;

  typedef struct packed {
    logic [DW-1:0] value;
    logic          lt;
    logic          eq;
    logic          gt;
    logic          dz;
    logic          use_div;
  } res_t;

  assign busy = 1'b0;

  logic               s1_vld_r;
  fpa_pkg::op_t       s1_op_r;
  logic signed [DW-1:0] s1_a_r, s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    s1_op_r <= fpa_pkg::op_t'(in_req_type);
    s1_a_r <= in_operand_a;
    s1_b_r <= in_operand_b;
  end

  logic signed [2*DW-1:0] prod_r;
  res_t                   s2_nxt;
  logic [NumWidth-1:0]    num_mag;
  logic [DW-1:0]          a_mag, b_mag;
  logic                   div_go;

  always_comb begin
    s2_nxt = '0;
    a_mag = s1_a_r[DW-1] ? (~s1_a_r + DW'(1)) : s1_a_r;
    b_mag = s1_b_r[DW-1] ? (~s1_b_r + DW'(1)) : s1_b_r;
    num_mag = {a_mag, FRAC_BITS'(0)};
    div_go = 1'b0;
    unique case (s1_op_r)
      fpa_pkg::OP_ADD: s2_nxt.value = s1_a_r + s1_b_r;
      fpa_pkg::OP_SUB: s2_nxt.value = s1_a_r - s1_b_r;
      fpa_pkg::OP_MUL: s2_nxt.use_div = 1'b0;
      fpa_pkg::OP_DIV: begin
        if (s1_b_r == '0) begin
          s2_nxt.dz = 1'b1;
        end else begin
          s2_nxt.use_div = 1'b1;
          div_go = s1_vld_r;
        end
      end
      fpa_pkg::OP_CMP: begin
        s2_nxt.lt = s1_a_r < s1_b_r;
        s2_nxt.eq = s1_a_r == s1_b_r;
        s2_nxt.gt = s1_a_r > s1_b_r;
      end
      fpa_pkg::OP_I2F: s2_nxt.value = DW'({s1_a_r, FRAC_BITS'(0)});
      fpa_pkg::OP_F2I: s2_nxt.value = DW'(s1_a_r >>> FRAC_BITS);
      default: s2_nxt.value = '0;
    endcase
  end

  logic          s2_vld_r;
  res_t          s2_r;
  logic          s2_mul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_r <= s2_nxt;
    s2_mul_r <= (s1_op_r == fpa_pkg::OP_MUL);
    prod_r <= (2*DW)'(s1_a_r) * (2*DW)'(s1_b_r);
  end

  logic [DW-1:0] div_quot;
  logic          div_vld;

  fpa_div_pipe #(
    .NumWidth(NumWidth)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_go),
    .in_num_mag(num_mag),
    .in_den_mag(b_mag),
    .in_neg    (s1_a_r[DW-1] ^ s1_b_r[DW-1]),
    .out_valid (div_vld),
    .out_quot  (div_quot)
  );

  res_t          s3_nxt;
  always_comb begin
    s3_nxt = s2_r;
    if (s2_mul_r) begin
      s3_nxt.value = prod_r[FRAC_BITS +: DW];
    end
  end

  logic [DelayLen-1:0] dl_vld_r;
  res_t                dl_r [DelayLen];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_vld_r <= '0;
    end else begin
      dl_vld_r <= {dl_vld_r[DelayLen-2:0], s2_vld_r};
    end
    dl_r[0] <= s3_nxt;
    for (int i = 1; i < DelayLen; i++) begin
      dl_r[i] <= dl_r[i-1];
    end
  end

  res_t tail;
  assign tail = dl_r[DelayLen-1];

  assign out_valid = dl_vld_r[DelayLen-1];
  assign out_result_value = (tail.use_div && div_vld) ? div_quot : tail.value;
  assign out_is_less = tail.lt;
  assign out_is_equal = tail.eq;
  assign out_is_greater = tail.gt;
  assign out_divide_by_zero = tail.dz;

endmodule

// File: tb/alu_scoreboard.sv
// Scoreboard class for the Q24.8 fixed-point ALU testbench: predicts each result.
// Depends on fpa_pkg for operation codes and widths.
`timescale 1ns / 100ps

class alu_scoreboard;
  typedef struct {
    logic signed [31:0] value;
    logic lt;
    logic eq;
    logic gt;
    logic dz;
  } alu_result_t;

  int unsigned frac_bits;
  alu_result_t pending_q[$];
  int error_count;

  function new(int unsigned fb);
    frac_bits = fb;
    error_count = 0;
  endfunction

  function void note_request(fpa_pkg::op_t op, logic signed [31:0] a,
                             logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] prod;
    wa = a;
    wb = b;
    r.value = '0;
    r.lt = 1'b0;
    r.eq = 1'b0;
    r.gt = 1'b0;
    r.dz = 1'b0;
    case (op)
      fpa_pkg::OP_ADD: r.value = a + b;
      fpa_pkg::OP_SUB: r.value = a - b;
      fpa_pkg::OP_MUL: begin
        prod = wa * wb;
        prod = prod >>> frac_bits;
        r.value = prod[31:0];
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          prod = (wa <<< frac_bits) / wb;
          r.value = prod[31:0];
        end
      end
      fpa_pkg::OP_CMP: begin
        r.lt = a < b;
        r.eq = a == b;
        r.gt = a > b;
      end
      fpa_pkg::OP_I2F: r.value = a <<< frac_bits;
      fpa_pkg::OP_F2I: r.value = a >>> frac_bits;
      default: ;
    endcase
    pending_q.push_back(r);
  endfunction

  function void check_result(logic signed [31:0] value, logic lt, logic eq,
                             logic gt, logic dz);
    alu_result_t e;
    if (pending_q.size() == 0) begin
      report_error("result with no request outstanding");
      return;
    end
    e = pending_q.pop_front();
    if (value !== e.value)
      report_error($sformatf("value got %h expected %h", value, e.value));
    if (lt !== e.lt) report_error("is_less mismatch");
    if (eq !== e.eq) report_error("is_equal mismatch");
    if (gt !== e.gt) report_error("is_greater mismatch");
    if (dz !== e.dz) report_error("divide_by_zero mismatch");
  endfunction

  function void report_error(string msg);
    error_count++;
    $display("MISMATCH: %s", msg);
  endfunction
endclass

// File: tb/testbench.sv
// Top-level testbench for fixed_point_alu_q24_8: directed and random requests.
// Depends on fpa_pkg, alu_scoreboard.sv and the ALU RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned FracBits = fpa_pkg::FracBitsDefault;
  localparam int Latency = 32 + FracBits;
  localparam int CycleLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [fpa_pkg::OpWidth-1:0] in_req_type = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic out_valid;
  logic signed [31:0] out_result_value;
  logic out_is_less, out_is_equal, out_is_greater, out_divide_by_zero;

  alu_scoreboard board = new(FracBits);
  int cycle_count = 0;

  fixed_point_alu_q24_8 #(.FRAC_BITS(FracBits)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) board.note_request(fpa_pkg::op_t'(in_req_type),
                                                    in_operand_a, in_operand_b);
    if (rst_n && out_valid) board.check_result(out_result_value, out_is_less,
                                               out_is_equal, out_is_greater,
                                               out_divide_by_zero);
  end

  task automatic send(fpa_pkg::op_t op, logic signed [31:0] a, logic signed [31:0] b);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 2047)) - 1024;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] a;
    logic signed [31:0] b;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(fpa_pkg::OP_ADD, 32'sh7FFFFFFF, 1);
    send(fpa_pkg::OP_SUB, 32'sh80000000, 1);
    send(fpa_pkg::OP_MUL, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send(fpa_pkg::OP_MUL, 32'sh80000000, 32'sh80000000);
    send(fpa_pkg::OP_MUL, -256, 384);
    send(fpa_pkg::OP_DIV, 1000, 0);
    send(fpa_pkg::OP_DIV, 32'sh80000000, -1);
    send(fpa_pkg::OP_DIV, -768, 512);
    send(fpa_pkg::OP_DIV, 32'sh7FFFFFFF, 1);
    send(fpa_pkg::OP_CMP, 5, 5);
    send(fpa_pkg::OP_CMP, 32'sh80000000, 32'sh7FFFFFFF);
    send(fpa_pkg::OP_CMP, 32'sh7FFFFFFF, 32'sh80000000);
    send(fpa_pkg::OP_I2F, 32'sh7FFFFFFF, -1);
    send(fpa_pkg::OP_I2F, -3, 0);
    send(fpa_pkg::OP_F2I, 32'sh80000000, 0);
    send(fpa_pkg::OP_F2I, -1, 0);
    send(fpa_pkg::OP_NOP, 32'shFFFFFFFF, 32'shFFFFFFFF);
    drain();
    for (int i = 0; i < 2000; i++) begin
      a = pick_operand();
      b = pick_operand();
      if ($urandom_range(0, 15) == 0) b = 0;
      if ($urandom_range(0, 7) == 0) b = a;
      send(fpa_pkg::op_t'($urandom_range(0, 7)), a, b);
      if (i == 1000) drain();
    end
    drain();
    repeat (Latency + 10) @(posedge clk);
    if (board.error_count == 0 && board.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: fixed_point_alu_q24_8.f
rtl/fpa_pkg.sv
rtl/fpa_div_pipe.sv
rtl/fixed_point_alu_q24_8.sv
tb/alu_scoreboard.sv
tb/testbench.sv
